// ===== src/color_temperature_to_rgb_core_macros.svh =====
// Assertion macros used by the checker of the color temperature core.
`ifndef COLOR_TEMPERATURE_TO_RGB_CORE_MACROS_SVH
`define COLOR_TEMPERATURE_TO_RGB_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTRGB_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("ctrgb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTRGB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("ctrgb assertion failed");

`endif

// ===== src/ctrgb_pkg.sv =====
// Types, breakpoint table and segment decoder of the color temperature core.
`timescale 1ns / 1ps

package ctrgb_pkg;

    localparam int T_W      = 16;
    localparam int SEG_W    = 4;
    localparam int W_W      = 11;
    localparam int NUM_W    = 19;
    localparam int RECIP_W  = 23;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int NUM_PTS  = 13;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam int Q_SHIFT  = 32;

    // Breakpoint temperatures in kelvin.
    localparam logic [T_W-1:0] KELVIN [NUM_PTS] = '{
        16'd1600, 16'd3000, 16'd3700, 16'd4500, 16'd5500, 16'd6500, 16'd7200,
        16'd8000, 16'd9000, 16'd10000, 16'd11000, 16'd12000, 16'd13000
    };

    // One classified temperature: segment index and offset above its lower point.
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [W_W-1:0]   w_hi;
    } t_seg_item;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_rgb;

    // Everything the back end needs about one segment. The reciprocal is
    // floor(2^32 / span), which gives a quotient that is exact or one low.
    typedef struct packed {
        logic [T_W-1:0]     kelvin_lo;
        logic [W_W-1:0]     span;
        logic [RECIP_W-1:0] recip;
        t_rgb               lo_c;
        t_rgb               hi_c;
    } t_seg_info;

    function automatic t_seg_info make_info(
        input logic [T_W-1:0]     kelvin_lo,
        input logic [W_W-1:0]     span,
        input logic [RECIP_W-1:0] recip,
        input logic [CH_W-1:0]    lo_r, lo_g, lo_b,
        input logic [CH_W-1:0]    hi_r, hi_g, hi_b
    );
        t_seg_info info;
        info.kelvin_lo = kelvin_lo;
        info.span      = span;
        info.recip     = recip;
        info.lo_c      = {lo_b, lo_g, lo_r};
        info.hi_c      = {hi_b, hi_g, hi_r};
        return info;
    endfunction

    function automatic t_seg_info seg_info(input logic [SEG_W-1:0] seg);
        t_seg_info info;
        unique case (seg)
            4'd0:  info = make_info(16'd1600, 11'd1400, 23'd3067833,
                                    8'd255, 8'd118, 8'd0, 8'd255, 8'd162, 8'd60);
            4'd1:  info = make_info(16'd3000, 11'd700, 23'd6135667,
                                    8'd255, 8'd162, 8'd60, 8'd255, 8'd180, 8'd107);
            4'd2:  info = make_info(16'd3700, 11'd800, 23'd5368709,
                                    8'd255, 8'd180, 8'd107, 8'd255, 8'd206, 8'd146);
            4'd3:  info = make_info(16'd4500, 11'd1000, 23'd4294967,
                                    8'd255, 8'd206, 8'd146, 8'd255, 8'd219, 8'd186);
            4'd4:  info = make_info(16'd5500, 11'd1000, 23'd4294967,
                                    8'd255, 8'd219, 8'd186, 8'd255, 8'd238, 8'd222);
            4'd5:  info = make_info(16'd6500, 11'd700, 23'd6135667,
                                    8'd255, 8'd238, 8'd222, 8'd255, 8'd249, 8'd251);
            4'd6:  info = make_info(16'd7200, 11'd800, 23'd5368709,
                                    8'd255, 8'd249, 8'd251, 8'd240, 8'd241, 8'd255);
            4'd7:  info = make_info(16'd8000, 11'd1000, 23'd4294967,
                                    8'd240, 8'd241, 8'd255, 8'd227, 8'd233, 8'd255);
            4'd8:  info = make_info(16'd9000, 11'd1000, 23'd4294967,
                                    8'd227, 8'd233, 8'd255, 8'd214, 8'd225, 8'd255);
            4'd9:  info = make_info(16'd10000, 11'd1000, 23'd4294967,
                                    8'd214, 8'd225, 8'd255, 8'd207, 8'd218, 8'd255);
            4'd10: info = make_info(16'd11000, 11'd1000, 23'd4294967,
                                    8'd207, 8'd218, 8'd255, 8'd200, 8'd213, 8'd255);
            default: info = make_info(16'd12000, 11'd1000, 23'd4294967,
                                    8'd200, 8'd213, 8'd255, 8'd191, 8'd211, 8'd255);
        endcase
        return info;
    endfunction

endpackage

// ===== src/ctrgb_front.sv =====
// Front end: takes temperatures, clamps them and finds the table segment.
`timescale 1ns / 1ps

module ctrgb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ctrgb_pkg::T_W-1:0]           i_temperature_k,
    output logic                                o_push,
    output ctrgb_pkg::t_seg_item                o_item,
    input  logic                                i_full
);

    logic                              r_valid;
    ctrgb_pkg::t_seg_item              r_item;
    ctrgb_pkg::t_seg_item              n_item;
    logic [ctrgb_pkg::T_W-1:0]         t_clamp;
    logic [ctrgb_pkg::SEG_W-1:0]       seg;
    logic [ctrgb_pkg::T_W-1:0]         offset;
    ctrgb_pkg::t_seg_info              info;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    // Temperatures outside the table are pulled onto its end points; the top
    // end point then falls into the last segment with full weight on its upper color.
    always_comb begin
        if (i_temperature_k < ctrgb_pkg::KELVIN[0]) begin
            t_clamp = ctrgb_pkg::KELVIN[0];
        end else if (i_temperature_k > ctrgb_pkg::KELVIN[ctrgb_pkg::NUM_PTS-1]) begin
            t_clamp = ctrgb_pkg::KELVIN[ctrgb_pkg::NUM_PTS-1];
        end else begin
            t_clamp = i_temperature_k;
        end
        seg = '0;
        for (int i = 1; i < ctrgb_pkg::NUM_PTS - 1; i++) begin
            if (ctrgb_pkg::KELVIN[i] < t_clamp) begin
                seg = ctrgb_pkg::SEG_W'(i);
            end
        end
        info        = ctrgb_pkg::seg_info(seg);
        offset      = t_clamp - info.kelvin_lo;
        n_item.seg  = seg;
        n_item.w_hi = offset[ctrgb_pkg::W_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/ctrgb_queue.sv =====
// Small first-in first-out queue of classified items between front and back end.
`timescale 1ns / 1ps

module ctrgb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ctrgb_pkg::t_seg_item  i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output ctrgb_pkg::t_seg_item  o_data,
    output logic                  o_not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctrgb_pkg::t_seg_item r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [CNT_W-1:0]     r_count;
    logic [PTR_W-1:0]     n_wr;
    logic [PTR_W-1:0]     n_rd;
    logic                 do_push;
    logic                 do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/ctrgb_back.sv =====
// Back end: three-stage interpolation pipeline with reciprocal division and output register.
`timescale 1ns / 1ps

module ctrgb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ctrgb_pkg::t_seg_item           i_q_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ctrgb_pkg::CH_W-1:0]     o_red,
    output logic [ctrgb_pkg::CH_W-1:0]     o_green,
    output logic [ctrgb_pkg::CH_W-1:0]     o_blue
);

    localparam int NUM_W  = ctrgb_pkg::NUM_W;
    localparam int CH_W   = ctrgb_pkg::CH_W;
    localparam int NUM_CH = ctrgb_pkg::NUM_CH;
    localparam int PROD_W = ctrgb_pkg::PROD_W;
    localparam int Q_LSB  = ctrgb_pkg::Q_SHIFT;

    // Stage 1: weighted sum; stage 2: reciprocal multiply; stage 3: correction.
    logic                               r_v1, r_v2, r_v3;
    logic                               en1, en2, en3;
    logic [ctrgb_pkg::SEG_W-1:0]        r_seg1, r_seg2;
    logic [NUM_CH-1:0][NUM_W-1:0]       r_num1, r_num2;
    logic [NUM_CH-1:0][CH_W-1:0]        r_q2;
    ctrgb_pkg::t_rgb                    r_rgb;

    logic [NUM_CH-1:0][NUM_W-1:0]       n_num1;
    logic [NUM_CH-1:0][CH_W-1:0]        n_q2;
    ctrgb_pkg::t_rgb                    n_rgb;
    ctrgb_pkg::t_seg_info               info1, info2, info3;
    logic [ctrgb_pkg::W_W-1:0]          w_lo;
    logic [PROD_W-1:0]                  prod;
    logic [NUM_W-1:0]                   q_span;
    logic [NUM_W-1:0]                   rem;

    assign en3   = !r_v3 || !i_stall;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_q_valid && en1;

    // Numerator c_lo*(T_hi-T) + c_hi*(T-T_lo); it never exceeds 255*1400.
    always_comb begin
        info1 = ctrgb_pkg::seg_info(i_q_item.seg);
        w_lo  = info1.span - i_q_item.w_hi;
        for (int c = 0; c < NUM_CH; c++) begin
            n_num1[c] = NUM_W'(info1.lo_c[c]) * NUM_W'(w_lo)
                      + NUM_W'(info1.hi_c[c]) * NUM_W'(i_q_item.w_hi);
        end
    end

    // Quotient estimate: numerator times floor(2^32/span), upper bits kept.
    always_comb begin
        info2 = ctrgb_pkg::seg_info(r_seg1);
        prod  = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            prod    = PROD_W'(r_num1[c]) * PROD_W'(info2.recip);
            n_q2[c] = prod[Q_LSB +: CH_W];
        end
    end

    // The estimate is exact or one low; one compare fixes it.
    always_comb begin
        info3  = ctrgb_pkg::seg_info(r_seg2);
        q_span = '0;
        rem    = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            q_span   = NUM_W'(r_q2[c]) * NUM_W'(info3.span);
            rem      = r_num2[c] - q_span;
            n_rgb[c] = r_q2[c] + CH_W'(rem >= NUM_W'(info3.span));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_q_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_seg1 <= i_q_item.seg;
            r_num1 <= n_num1;
        end
        if (en2) begin
            r_seg2 <= r_seg1;
            r_num2 <= r_num1;
            r_q2   <= n_q2;
        end
        if (en3 && r_v2) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_v3;
    assign o_red   = r_rgb[0];
    assign o_green = r_rgb[1];
    assign o_blue  = r_rgb[2];

endmodule

// ===== src/color_temperature_to_rgb_core.sv =====
// Top level of the color temperature to RGB core.
`timescale 1ns / 1ps

// The core turns a temperature in whole kelvin into an 8-bit RGB color by
// piecewise linear interpolation over a fixed table of thirteen breakpoints
// from 1600 K to 13000 K. Temperatures at or below 1600 K give the 1600 K
// color and those at or above 13000 K give the 13000 K color. Inside the table
// each channel is (c_lo*(T_hi-T) + c_hi*(T-T_lo)) / (T_hi-T_lo), truncated,
// and a temperature that lands exactly on a breakpoint yields that
// breakpoint's color. The core takes one transfer per clock cycle and
// delivers one result per cycle as long as the output side is not stalled.
// On its way to the output a result is registered in the front end, which
// clamps the temperature and finds the table segment, then in the queue, and
// then in the three stages of the back end, which form the channel numerators,
// multiply them by the segment's reciprocal span and correct the quotient by
// one compare, the last stage being the output register. The queue of
// QUEUE_DEPTH entries decouples the two halves, so the input side sees
// o_stall only once the queue and the front end register are both full; in
// total the core holds up to QUEUE_DEPTH + 4 items. Both channels use valid
// and stall: a transfer happens at a rising clock edge where valid is high
// and stall is low, and a stalled output holds its color steady.

module color_temperature_to_rgb_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ctrgb_pkg::T_W-1:0]     i_temperature_k,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ctrgb_pkg::CH_W-1:0]    o_red,
    output logic [ctrgb_pkg::CH_W-1:0]    o_green,
    output logic [ctrgb_pkg::CH_W-1:0]    o_blue
);

    logic                      push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_not_empty;
    ctrgb_pkg::t_seg_item      front_item;
    ctrgb_pkg::t_seg_item      q_item;

    // Front end: clamps the temperature and classifies it by segment.
    ctrgb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_temperature_k (i_temperature_k),
        .o_push          (push),
        .o_item          (front_item),
        .i_full          (q_full)
    );

    // Queue between the halves, so a stalled output does not stop intake at once.
    ctrgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (front_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_data      (q_item),
        .o_not_empty (q_not_empty)
    );

    // Back end: interpolation pipeline ending in the output register.
    ctrgb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

endmodule

// ===== src/ctrgb_checker.sv =====
// Port-level checker of the color temperature core and its bind statement.
`timescale 1ns / 1ps
`include "color_temperature_to_rgb_core_macros.svh"

module ctrgb_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [ctrgb_pkg::CH_W-1:0]    o_red,
    input  logic [ctrgb_pkg::CH_W-1:0]    o_green,
    input  logic [ctrgb_pkg::CH_W-1:0]    o_blue
);

    localparam int CAP   = QUEUE_DEPTH + 4;
    localparam int CNT_W = $clog2(CAP + 2);

    logic                            in_xfer;
    logic                            out_xfer;
    logic [CNT_W-1:0]                r_inflight;
    logic                            color_ok;
    logic [3*ctrgb_pkg::CH_W-1:0]    out_color;

    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = o_valid && !i_stall;
    assign color_ok  = (o_red >= 8'd191) && (o_green >= 8'd118) && (o_green <= 8'd249);
    assign out_color = {o_red, o_green, o_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // A result never goes out without an item inside the core.
    `CTRGB_ASSERT_IMPLY(a_no_phantom, i_clk, i_rst_n, out_xfer, r_inflight != '0)

    // Once the core holds all it can, the input side must be stalled.
    `CTRGB_ASSERT_IMPLY(a_full_stalls, i_clk, i_rst_n, r_inflight >= CNT_W'(CAP), o_stall)

    // Every interpolated color is a blend of table colors, so its channels stay in range.
    `CTRGB_ASSERT_IMPLY(a_color_range, i_clk, i_rst_n, o_valid, color_ok)

    // A stalled result holds.
    `CTRGB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_color))

endmodule

bind color_temperature_to_rgb_core ctrgb_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ctrgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_red           (o_red),
    .o_green         (o_green),
    .o_blue          (o_blue)
);
